@@ hw/rtl/rbs_pkg.sv @@
// rbs_pkg: shared widths, register indexes, sequencer op codes and helpers
// for the region box smoother. No dependencies.
package rbs_pkg;

  localparam int DIM_W   = 13;   // pixel coordinates and frame sizes
  localparam int FRAC_W  = 17;   // Q1.16 fractions, one is 65536
  localparam int EDGE_W  = 14;   // far edge before clamping, up to twice a dimension
  localparam int DIFF_W  = 16;   // signed edge jump
  localparam int PROD_W  = FRAC_W + 1 + DIFF_W;
  localparam int THR_W   = FRAC_W + DIM_W;
  localparam int CFG_A_W = 3;
  localparam int OP_W    = 4;

  localparam int MAX_DIM_DEF = 4096;

  localparam logic [FRAC_W-1:0] ONE_Q16  = FRAC_W'(65536);
  localparam logic [FRAC_W-1:0] HALF_Q16 = FRAC_W'(32768);

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_MARGIN       = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_UPDATE       = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_MIN          = 3'd4;

  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = DIM_W'(480);
  localparam logic [FRAC_W-1:0] RST_MARGIN       = FRAC_W'(6554);
  localparam logic [FRAC_W-1:0] RST_UPDATE       = FRAC_W'(32768);
  localparam logic [FRAC_W-1:0] RST_MIN          = FRAC_W'(13107);

  // multiplier ops, issued in this order
  localparam logic [OP_W-1:0] OP_MW   = 4'd0;   // width margin
  localparam logic [OP_W-1:0] OP_MH   = 4'd1;   // height margin
  localparam logic [OP_W-1:0] OP_CX   = 4'd2;
  localparam logic [OP_W-1:0] OP_CY   = 4'd3;
  localparam logic [OP_W-1:0] OP_CW   = 4'd4;
  localparam logic [OP_W-1:0] OP_CH   = 4'd5;
  localparam logic [OP_W-1:0] OP_TW   = 4'd6;   // min extent threshold, x axis
  localparam logic [OP_W-1:0] OP_TH   = 4'd7;   // min extent threshold, y axis
  localparam logic [OP_W-1:0] OP_SL   = 4'd8;   // smooth left
  localparam logic [OP_W-1:0] OP_ST   = 4'd9;   // smooth top
  localparam logic [OP_W-1:0] OP_SR   = 4'd10;  // smooth right
  localparam logic [OP_W-1:0] OP_SB   = 4'd11;  // smooth bottom
  localparam logic [OP_W-1:0] OP_LAST = OP_SB;

  typedef struct packed {
    logic            issue;   // multiplier operands valid for op
    logic [OP_W-1:0] op;
    logic            wb_en;   // product of wb_op is in the multiplier register
    logic [OP_W-1:0] wb_op;
    logic            fix;     // finish: grow, clamp, store and emit
  } rbs_ctl_t;

  typedef struct packed {
    logic [DIM_W-1:0] lo;
    logic [DIM_W-1:0] hi;
  } rbs_axis_t;

  function automatic logic [FRAC_W-1:0] sat_q16(input logic [FRAC_W-1:0] v);
    sat_q16 = (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

@@ hw/rtl/rbs_mul.sv @@
// rbs_mul: the shared multiplier, unsigned Q1.16 fraction times a signed
// operand, product registered. Depends on rbs_pkg.
module rbs_mul (
  input  logic                               clk,
  input  logic [rbs_pkg::FRAC_W-1:0]         mul_a,
  input  logic signed [rbs_pkg::DIFF_W-1:0]  mul_b,
  output logic signed [rbs_pkg::PROD_W-1:0]  prod_r
);
  import rbs_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = $signed({1'b0, mul_a}) * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

@@ hw/rtl/rbs_ctrl.sv @@
// rbs_ctrl: sequencer stepping the shared multiplier through the op list,
// then the finish step that waits for a free output register. Depends on rbs_pkg.
module rbs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               out_free,
  output logic               idle,
  output rbs_pkg::rbs_ctl_t  ctl
);
  import rbs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [OP_W-1:0] step_r, step_nxt;
  logic            wb_en_r;
  logic [OP_W-1:0] wb_op_r;
  logic            issue;

  assign idle  = (state_r == S_IDLE);
  assign issue = (state_r == S_RUN) && (step_r <= OP_LAST);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RUN;
          step_nxt  = '0;
        end
      end
      S_RUN: begin
        step_nxt = step_r + 1'b1;
        // the step after the last issue is kept for its writeback
        if (step_r == OP_LAST + 1'b1) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      wb_en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      wb_en_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    wb_op_r <= step_r;
  end

  always_comb begin
    ctl.issue = issue;
    ctl.op    = step_r;
    ctl.wb_en = wb_en_r;
    ctl.wb_op = wb_op_r;
    ctl.fix   = (state_r == S_FIX) && out_free;
  end

endmodule

@@ hw/rtl/roi_box_smoother.sv @@
// roi_box_smoother: smooths one detected box per frame into a pixel region.
// One item is taken at a time: the sequencer steps through twelve multiplier issues, a
// writeback step and a finish step that waits for a free output register, then idles;
// out_tvalid is registered from the finish step. in_tready is high only while the sequencer
// is idle; a finished item waits in the output register and the next item can be taken meanwhile.
// Reset (rst_n, synchronous): registers to defaults, region zero, first box pending.
module roi_box_smoother #(
  parameter int MAX_DIM = rbs_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [71:0]                   in_tdata,   // rel_x, rel_y, rel_w, rel_h (17b each), pad
  input  logic [0:0]                    in_tuser,   // restart
  // result items
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [55:0]                   out_tdata,  // roi_x, roi_y, roi_w, roi_h (13b each), pad
  // configuration
  input  logic                          cfg_we,
  input  logic [rbs_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [rbs_pkg::FRAC_W-1:0]    cfg_wdata
);
  import rbs_pkg::*;

  // ---------------------------------------------------------------- config
  logic [DIM_W-1:0]  frame_width_r, frame_height_r;
  logic [FRAC_W-1:0] margin_r, update_r, min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      margin_r       <= RST_MARGIN;
      update_r       <= RST_UPDATE;
      min_r          <= RST_MIN;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[DIM_W-1:0];
        REG_MARGIN:       margin_r       <= cfg_wdata;
        REG_UPDATE:       update_r       <= cfg_wdata;
        REG_MIN:          min_r          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective frame size: zero reads as one, above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      eff_dim = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      eff_dim = DIM_W'(MAX_DIM);
    end else begin
      eff_dim = v;
    end
  endfunction

  logic [DIM_W-1:0]  dim_w, dim_h;
  logic [FRAC_W-1:0] mf, uf, nf;

  assign dim_w = eff_dim(frame_width_r);
  assign dim_h = eff_dim(frame_height_r);
  assign mf    = sat_q16(margin_r);
  assign uf    = sat_q16(update_r);
  assign nf    = sat_q16(min_r);

  // ------------------------------------------------------------ sequencer
  rbs_ctl_t ctl;
  logic     idle, in_fire, out_free, out_valid_r;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && idle;
  assign out_free  = !out_valid_r || out_tready;

  rbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .out_free (out_free),
    .idle     (idle),
    .ctl      (ctl)
  );

  // ------------------------------------------------------- item capture
  logic [FRAC_W-1:0] rx_r, ry_r, rw_r, rh_r;
  logic              first_r, first_pending_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rx_r    <= sat_q16(in_tdata[16:0]);
      ry_r    <= sat_q16(in_tdata[33:17]);
      rw_r    <= sat_q16(in_tdata[50:34]);
      rh_r    <= sat_q16(in_tdata[67:51]);
      first_r <= first_pending_r | in_tuser[0];   // restart acts as a fresh start
    end
  end

  // ------------------------------------------------------ stored region
  logic [DIM_W-1:0] box_l_r, box_t_r, box_r_r, box_b_r;

  // ------------------------------------------------------ working values
  logic [DIM_W-1:0]  mw_r, mh_r, cx_r, cy_r, cw_r, ch_r;
  logic [THR_W-1:0]  tw_r, th_r;
  logic [EDGE_W-1:0] sl_r, st_r, sr_r, sb_r;
  logic [EDGE_W-1:0] xr_raw, xb_raw;

  assign xr_raw = EDGE_W'(cx_r) + EDGE_W'(cw_r);
  assign xb_raw = EDGE_W'(cy_r) + EDGE_W'(ch_r);

  // ------------------------------------------- multiplier operand select
  logic [EDGE_W-1:0]        sm_x;
  logic [DIM_W-1:0]         sm_s, sm_m;
  logic signed [DIFF_W-1:0] sm_d, sm_abs;
  logic [FRAC_W-1:0]        alpha;
  logic [FRAC_W-1:0]        mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_r;

  always_comb begin
    case (ctl.op)
      OP_SL:   begin sm_x = EDGE_W'(cx_r); sm_s = box_l_r; sm_m = mw_r; end
      OP_ST:   begin sm_x = EDGE_W'(cy_r); sm_s = box_t_r; sm_m = mh_r; end
      OP_SR:   begin sm_x = xr_raw;        sm_s = box_r_r; sm_m = mw_r; end
      default: begin sm_x = xb_raw;        sm_s = box_b_r; sm_m = mh_r; end
    endcase
  end

  // a jump of at least the margin switches to equal weighting
  assign sm_d   = $signed({2'b00, sm_x}) - $signed({3'b000, sm_s});
  assign sm_abs = sm_d[DIFF_W-1] ? -sm_d : sm_d;
  assign alpha  = ($unsigned(sm_abs) >= {3'b000, sm_m}) ? HALF_Q16 : uf;

  always_comb begin
    mul_a = alpha;
    mul_b = sm_d;
    case (ctl.op)
      OP_MW: begin mul_a = mf;   mul_b = $signed({3'b000, dim_w}); end
      OP_MH: begin mul_a = mf;   mul_b = $signed({3'b000, dim_h}); end
      OP_CX: begin mul_a = rx_r; mul_b = $signed({3'b000, dim_w}); end
      OP_CY: begin mul_a = ry_r; mul_b = $signed({3'b000, dim_h}); end
      OP_CW: begin mul_a = rw_r; mul_b = $signed({3'b000, dim_w}); end
      OP_CH: begin mul_a = rh_r; mul_b = $signed({3'b000, dim_h}); end
      OP_TW: begin mul_a = nf;   mul_b = $signed({3'b000, dim_w}); end
      OP_TH: begin mul_a = nf;   mul_b = $signed({3'b000, dim_h}); end
      default: ;
    endcase
  end

  rbs_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // --------------------------------------------------------- writeback
  // smoothed edge = old + floor(alpha * (new - old) / 65536)
  logic [DIM_W-1:0]       wb_s;
  logic signed [PROD_W-16:0] wb_sum;
  logic [EDGE_W-1:0]      wb_edge;

  always_comb begin
    case (ctl.wb_op)
      OP_SL:   wb_s = box_l_r;
      OP_ST:   wb_s = box_t_r;
      OP_SR:   wb_s = box_r_r;
      default: wb_s = box_b_r;
    endcase
  end

  assign wb_sum  = $signed({{(PROD_W-15-DIM_W){1'b0}}, wb_s})
                 + $signed({prod_r[PROD_W-1], prod_r[PROD_W-1:16]});
  assign wb_edge = wb_sum[EDGE_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.wb_en) begin
      case (ctl.wb_op)
        OP_MW:   mw_r <= prod_r[16+DIM_W-1:16];
        OP_MH:   mh_r <= prod_r[16+DIM_W-1:16];
        OP_CX:   cx_r <= prod_r[16+DIM_W-1:16];
        OP_CY:   cy_r <= prod_r[16+DIM_W-1:16];
        OP_CW:   cw_r <= prod_r[16+DIM_W-1:16];
        OP_CH:   ch_r <= prod_r[16+DIM_W-1:16];
        OP_TW:   tw_r <= prod_r[THR_W-1:0];
        OP_TH:   th_r <= prod_r[THR_W-1:0];
        OP_SL:   sl_r <= wb_edge;
        OP_ST:   st_r <= wb_edge;
        OP_SR:   sr_r <= wb_edge;
        OP_SB:   sb_r <= wb_edge;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ finish
  // grow by the margin, clamp to the frame, full frame if too narrow
  function automatic rbs_axis_t fix_axis(input logic [EDGE_W-1:0] lo,
                                         input logic [EDGE_W-1:0] hi,
                                         input logic [DIM_W-1:0]  m,
                                         input logic [DIM_W-1:0]  dim,
                                         input logic [THR_W-1:0]  thr);
    logic signed [DIFF_W:0]   a;
    logic [EDGE_W:0]          b;
    logic [EDGE_W-1:0]        a_c;
    logic [DIM_W-1:0]         b_c;
    logic signed [DIFF_W-1:0] ext;
    logic signed [DIFF_W+16:0] ext_q;
    rbs_axis_t                res;
    a     = $signed({3'b000, lo}) - $signed({4'b0000, m});
    b     = {1'b0, hi} + {2'b00, m};
    a_c   = a[DIFF_W] ? '0 : a[EDGE_W-1:0];
    b_c   = (b > {2'b00, dim}) ? dim : b[DIM_W-1:0];
    ext   = $signed({3'b000, b_c}) - $signed({2'b00, a_c});
    ext_q = {ext[DIFF_W-1], ext, 16'b0};
    if (ext_q < $signed({3'b000, thr})) begin
      res.lo = '0;
      res.hi = dim;
    end else begin
      res.lo = a_c[DIM_W-1:0];
      res.hi = b_c;
    end
    fix_axis = res;
  endfunction

  logic [EDGE_W-1:0] pl, pt, pr, pb;
  rbs_axis_t         ax_x, ax_y;

  // first box after reset or restart is taken unsmoothed
  assign pl = first_r ? EDGE_W'(cx_r) : sl_r;
  assign pt = first_r ? EDGE_W'(cy_r) : st_r;
  assign pr = first_r ? xr_raw        : sr_r;
  assign pb = first_r ? xb_raw        : sb_r;

  assign ax_x = fix_axis(pl, pr, mw_r, dim_w, tw_r);
  assign ax_y = fix_axis(pt, pb, mh_r, dim_h, th_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_l_r         <= '0;
      box_t_r         <= '0;
      box_r_r         <= '0;
      box_b_r         <= '0;
      first_pending_r <= 1'b1;
    end else if (ctl.fix) begin
      box_l_r         <= ax_x.lo;
      box_t_r         <= ax_y.lo;
      box_r_r         <= ax_x.hi;
      box_b_r         <= ax_y.hi;
      first_pending_r <= 1'b0;
    end
  end

  // ----------------------------------------------------- output register
  logic [DIM_W-1:0] roi_x_r, roi_y_r, roi_w_r, roi_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fix) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fix) begin
      roi_x_r <= ax_x.lo;
      roi_y_r <= ax_y.lo;
      roi_w_r <= ax_x.hi - ax_x.lo;
      roi_h_r <= ax_y.hi - ax_y.lo;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, roi_h_r, roi_w_r, roi_y_r, roi_x_r};

endmodule
